// ===== rtl/u8st_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 sanitize/truncate block.
// No dependencies; imported by every RTL module of the block.
package u8st_pkg;

	localparam int unsigned MAX_CAPACITY = 256;
	localparam int unsigned CAP_W        = $clog2(MAX_CAPACITY + 1);
	localparam int unsigned GRP_N        = 4;
	localparam int unsigned GRP_CNT_W    = $clog2(GRP_N + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// Byte codes
	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	// Lead and continuation patterns
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;

	// Result group produced by one input byte
	typedef struct packed {
		logic [GRP_CNT_W-1:0]  cnt;
		logic [GRP_N-1:0][7:0] data;
		logic                  last;
	} grp_t;

	// Sequence length announced by a lead byte
	function automatic logic [2:0] seq_length(input logic [7:0] lead);
		logic [2:0] len;
		len = 3'd1;
		if ((lead & LEAD2_MASK) == LEAD2_TAG) len = 3'd2;
		else if ((lead & LEAD3_MASK) == LEAD3_TAG) len = 3'd3;
		else if ((lead & LEAD4_MASK) == LEAD4_TAG) len = 3'd4;
		return len;
	endfunction

	// Clamp the capacity register into its usable range
	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] r;
		r = c;
		if (c == '0) r = CAP_W'(1);
		else if (c > CAP_W'(MAX_CAPACITY)) r = CAP_W'(MAX_CAPACITY);
		return r;
	endfunction

endpackage

// ===== rtl/u8st_if.sv =====
// Handshake channel interfaces for the UTF-8 sanitize/truncate block.
// Standalone: no package dependency.
interface u8st_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface u8st_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;

	modport source(output valid, output out_byte, output is_last, input ready);
	modport sink(input valid, input out_byte, input is_last, output ready);
endinterface

// ===== rtl/u8st_core.sv =====
// String state and per-byte filter: turns one source byte into a result group.
// Depends on u8st_pkg.
module u8st_core
	import u8st_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_in,
	input  logic [CAP_W-1:0] capacity,
	output grp_t             grp
);

	logic             stopped_q, stopped_d;
	logic [CAP_W-1:0] count_q, count_d;
	logic [2:0]       plen_q, plen_d;
	logic [1:0]       prcv_q, prcv_d;
	logic [7:0]       pend_q [3];

	logic             pend_we;
	logic [1:0]       pend_idx;
	logic [CAP_W-1:0] cap;
	logic [CAP_W:0]   need;
	logic [2:0]       rcv_nx;
	logic [2:0]       len;

	// Filter one byte against the current string state
	always_comb begin
		cap       = eff_cap(capacity);
		stopped_d = stopped_q;
		count_d   = count_q;
		plen_d    = plen_q;
		prcv_d    = prcv_q;
		pend_we   = 1'b0;
		pend_idx  = prcv_q;
		rcv_nx    = {1'b0, prcv_q} + 3'd1;
		len       = seq_length(byte_in);
		need      = {1'b0, count_q} + (CAP_W+1)'(1);
		grp.cnt   = '0;
		grp.data  = '0;
		grp.last  = 1'b0;

		if (byte_in == BYTE_NUL) begin
			// terminator: emit and clear for the next string
			grp.cnt     = GRP_CNT_W'(1);
			grp.data[0] = BYTE_NUL;
			grp.last    = 1'b1;
			stopped_d   = 1'b0;
			count_d     = '0;
			plen_d      = '0;
			prcv_d      = '0;
		end else if (stopped_q) begin
			// drop until terminator
		end else if (plen_q != 3'd0) begin
			if ((byte_in & CONT_MASK) != CONT_TAG) begin
				stopped_d = 1'b1;
				plen_d    = '0;
				prcv_d    = '0;
			end else begin
				pend_we = (prcv_q != 2'd3);
				if (rcv_nx < plen_q) begin
					prcv_d = rcv_nx[1:0];
				end else begin
					plen_d = '0;
					prcv_d = '0;
					need   = {1'b0, count_q} + (CAP_W+1)'(plen_q);
					if (need >= {1'b0, cap}) begin
						stopped_d = 1'b1;
					end else begin
						// held bytes then this byte as the final one
						grp.cnt     = GRP_CNT_W'(plen_q);
						grp.data[0] = pend_q[0];
						grp.data[1] = (plen_q == 3'd2) ? byte_in : pend_q[1];
						grp.data[2] = (plen_q == 3'd3) ? byte_in : pend_q[2];
						grp.data[3] = byte_in;
						count_d     = count_q + CAP_W'(plen_q);
					end
				end
			end
		end else if (need >= {1'b0, cap}) begin
			stopped_d = 1'b1;
		end else if (byte_in == BYTE_TAB) begin
			grp.cnt     = GRP_CNT_W'(1);
			grp.data[0] = BYTE_SPACE;
			count_d     = count_q + CAP_W'(1);
		end else if (byte_in < CTRL_LIMIT) begin
			// drop control byte
		end else if (len == 3'd1) begin
			grp.cnt     = GRP_CNT_W'(1);
			grp.data[0] = byte_in;
			count_d     = count_q + CAP_W'(1);
		end else begin
			// hold lead byte
			pend_we  = 1'b1;
			pend_idx = 2'd0;
			plen_d   = len;
			prcv_d   = 2'd1;
		end
	end

	// Advance string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			count_q   <= '0;
			plen_q    <= '0;
			prcv_q    <= '0;
		end else if (step) begin
			stopped_q <= stopped_d;
			count_q   <= count_d;
			plen_q    <= plen_d;
			prcv_q    <= prcv_d;
		end
	end

	// Hold pending sequence bytes
	always_ff @(posedge clk) begin
		if (step && pend_we) begin
			pend_q[pend_idx] <= byte_in;
		end
	end

endmodule

// ===== rtl/u8st_obuf.sv =====
// Result group register that hands out its bytes one request at a time.
// Depends on u8st_pkg and u8st_out_if.
module u8st_obuf
	import u8st_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  grp_t          grp_in,
	output logic          can_load,
	u8st_out_if.source    dout
);

	logic [GRP_CNT_W-1:0]  cnt_q;
	logic [GRP_N-1:0][7:0] data_q;
	logic                  last_q;
	logic                  fire;

	assign fire       = dout.valid && dout.ready;
	assign can_load   = (cnt_q == '0) || ((cnt_q == GRP_CNT_W'(1)) && dout.ready);
	assign dout.valid = (cnt_q != '0);
	assign dout.out_byte = data_q[0];
	assign dout.is_last  = last_q;

	// Load a new group or drain the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= grp_in.cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - GRP_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= grp_in.data;
			last_q <= grp_in.last;
		end else if (fire) begin
			data_q <= data_q >> 8;
		end
	end

endmodule

// ===== rtl/utf8_sanitize_truncate.sv =====
// Top level of the UTF-8 sanitize/truncate filter: input register, filter core,
// result group register. Depends on u8st_pkg, u8st_if, u8st_core, u8st_obuf.
//
// Usage:
//   din carries one source byte per request; a zero byte ends the string.
//   dout carries filtered bytes; the terminator has is_last set.
//   cfg_we/cfg_wdata write the capacity register (buffer size with terminator).
//   Write capacity only between strings, with both channels idle.
// Timing:
//   An accepted byte waits in the input register, is filtered by the core and
//   its results are loaded into the result group register, which drives dout.
//   One byte enters per cycle while each byte yields at most one result and
//   dout keeps up. A completed 2/3/4-byte sequence leaves as that many output
//   requests, one per cycle if dout is ready; the input register waits while the
//   group register holds more than one, or holds one that dout is not taking.
// Reset:
//   arst_n clears the string state, empties both registers and sets capacity
//   to 64.
// Stall:
//   When dout.ready is low, results hold; the input register still takes one
//   byte, then din.ready drops until the group register frees up.
module utf8_sanitize_truncate
	import u8st_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	u8st_in_if.sink          din,
	u8st_out_if.source       dout
);

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic [CAP_W-1:0] cap_q;
	logic             adv;
	logic             can_load;
	grp_t             grp;

	assign adv       = vld_s1 && can_load;
	assign din.ready = !vld_s1 || adv;

	// Hold capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (din.valid && din.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.data_byte;
		end
	end

	u8st_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.byte_in  (byte_s1),
		.capacity (cap_q),
		.grp      (grp)
	);

	u8st_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.grp_in   (grp),
		.can_load (can_load),
		.dout     (dout)
	);

	// The terminator result always carries a zero byte
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.is_last |-> dout.out_byte == BYTE_NUL)
		else $error("terminator result carries a nonzero byte");

	// A stalled input register keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(byte_s1))
		else $error("input register lost a byte while stalled");

	// A loaded non-empty group is then presented on dout
	a_grp_free: assert property (@(posedge clk) disable iff (!arst_n)
		adv && grp.cnt != '0 |=> dout.valid)
		else $error("loaded result group not presented");

	// Group count never exceeds the longest sequence
	a_grp_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> grp.cnt <= GRP_CNT_W'(GRP_N))
		else $error("result group too large");

endmodule
